FILE: hdl/rau_pkg.sv
// Types and opcode constants for the rational arithmetic unit.
// Depends on nothing; every other file imports it.
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               cmp_less;
        logic               cmp_equal;
        logic               cmp_greater;
        logic               status;
    } t_out_beat;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture operands
        logic mul_lo;   // first cross products (low halves)
        logic mul_hi;   // finish cross products
        logic form;     // form numerator and denominator
        logic gcd_init; // start gcd
        logic gcd_step; // one gcd subtract/shift step
        logic div_init; // start divisions by gcd
        logic div_step; // one quotient bit for both divisions
        logic finish;   // build result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic err;      // immediate error
        logic is_cmp;   // compare opcode
        logic zero_num; // numerator zero
        logic gcd_done;
        logic div_done;
    } t_stat;

endpackage

FILE: hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: usage
// Pulse start with the operands and opcode on i_in while busy is low;
// the beat is taken at that edge. The block then computes cross products
// in two multiply passes, reduces by a binary gcd (one subtract or shift
// per cycle) and divides numerator and denominator by the gcd with a
// restoring divider, both quotients in parallel.
// Compare, errors and zero results skip the gcd and the division.
// One item at a time: busy stays high until the result is out, and the
// next beat is taken only once busy is low again.
// The result appears on o_out for exactly one cycle with o_valid high;
// the receiver cannot stall and must take it then.
// Reset (synchronous, active low) returns the controller to idle; the
// datapath holds no state that matters between items.
// Depends on rau_pkg, rau_ctrl and rau_dp.
module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rau_pkg::t_in_beat   i_in,
    output logic                o_valid,
    output rau_pkg::t_out_beat  o_out
);
    import rau_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    rau_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_out  (o_out)
    );
endmodule

FILE: hdl/rau_ctrl.sv
// Controller state machine for the rational arithmetic unit.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import rau_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MULLO = 9'b000000010,
        S_MULHI = 9'b000000100,
        S_FORM  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_GCD   = 9'b000100000,
        S_DINIT = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Advance the sequence.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULLO;
                end
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_FORM;
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.err || i_stat.is_cmp || i_stat.zero_num) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = S_DINIT;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN);

    // The finish state is always followed by idle.
    a_fin_from_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE)) else $error("fin not one cycle");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_MULLO))
        else $error("start lost");
    a_gcd_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD && i_stat.gcd_done) |=> (r_state == S_DINIT))
        else $error("gcd exit");
endmodule

FILE: hdl/rau_dp.sv
// Datapath for the rational arithmetic unit: cross products, binary gcd,
// and restoring division by the gcd. Depends on rau_pkg.
module rau_dp #(
    parameter int OPERAND_BITS = 32
) (
    input  logic              i_clk,
    input  rau_pkg::t_in_beat i_in,
    input  rau_pkg::t_cmd     i_cmd,
    output rau_pkg::t_stat    o_stat,
    output rau_pkg::t_out_beat o_out
);
    import rau_pkg::*;

    localparam int NB = OPERAND_BITS;
    localparam int HB = 16;

    logic [2:0]         r_op;
    logic signed [NB-1:0] r_an, r_bn;
    logic [NB-2:0]      r_ad, r_bd;
    logic               r_err;
    // cross products: p0 = an*bd, p1 = bn*ad, p2 = an*bn, p3 = ad*bd
    logic [63:0] r_p0, r_p1, r_p2, r_p3;
    logic [63:0] r_mn, r_md;
    logic        r_neg;
    logic [63:0] r_gx, r_gy;
    logic [6:0]  r_shift;
    logic [63:0] r_g;
    logic [63:0] r_qn, r_qd, r_rn, r_rd;
    logic [6:0]  r_cnt;
    logic        r_lt, r_eq, r_gt;

    // Operands widened to 64 bits: numerators sign-extended, denominators zero-extended.
    logic signed [63:0] w_an, w_bn, w_ad, w_bd;
    assign w_an = 64'(r_an);
    assign w_bn = 64'(r_bn);
    assign w_ad = 64'({1'b0, r_ad});
    assign w_bd = 64'({1'b0, r_bd});

    // Multiply in two passes: split the second factor into its low 16 bits and the signed bits above them.
    // Both factors fit in 33 signed bits, so each pass is a 33 x 17 product.
    function automatic logic [63:0] half_prod(logic signed [63:0] x,
                                              logic signed [63:0] y,
                                              logic hi);
        logic signed [16:0] part;
        logic signed [49:0] prod;
        begin
            if (hi) part = y[32:16];
            else    part = {1'b0, y[HB-1:0]};
            prod = $signed(x[32:0]) * part;
            half_prod = 64'(prod);
            if (hi) half_prod = half_prod << HB;
        end
    endfunction

    logic signed [63:0] w_num, w_den;
    always_comb begin
        w_num = '0;
        w_den = $signed(r_p3);
        case (r_op)
            OP_ADD: w_num = $signed(r_p0) + $signed(r_p1);
            OP_SUB: w_num = $signed(r_p0) - $signed(r_p1);
            OP_MUL: w_num = $signed(r_p2);
            default: begin
                w_num = $signed(r_p0);
                w_den = $signed(r_p1);
            end
        endcase
    end

    // Binary gcd step.
    logic [63:0] w_diff;
    assign w_diff = (r_gx > r_gy) ? r_gx - r_gy : r_gy - r_gx;

    // Restoring division step for both quotients.
    logic [64:0] w_tn, w_td;
    assign w_tn = {r_rn, r_qn[63]} - {1'b0, r_g};
    assign w_td = {r_rd, r_qd[63]} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in.opcode;
            r_an  <= i_in.a_num[NB-1:0];
            r_bn  <= i_in.b_num[NB-1:0];
            r_ad  <= i_in.a_den[NB-2:0];
            r_bd  <= i_in.b_den[NB-2:0];
        end
        if (i_cmd.mul_lo) begin
            r_p0 <= half_prod(w_an, w_bd, 1'b0);
            r_p1 <= half_prod(w_bn, w_ad, 1'b0);
            r_p2 <= half_prod(w_an, w_bn, 1'b0);
            r_p3 <= half_prod(w_ad, w_bd, 1'b0);
            r_err <= (r_ad == '0) || (r_bd == '0) || (r_op > OP_CMP) ||
                     (r_op == OP_DIV && r_bn == '0);
        end
        if (i_cmd.mul_hi) begin
            r_p0 <= r_p0 + half_prod(w_an, w_bd, 1'b1);
            r_p1 <= r_p1 + half_prod(w_bn, w_ad, 1'b1);
            r_p2 <= r_p2 + half_prod(w_an, w_bn, 1'b1);
            r_p3 <= r_p3 + half_prod(w_ad, w_bd, 1'b1);
        end
        if (i_cmd.form) begin
            r_neg <= w_num[63] ^ w_den[63];
            r_mn  <= w_num[63] ? 64'd0 - w_num : w_num;
            r_md  <= w_den[63] ? 64'd0 - w_den : w_den;
            r_lt  <= $signed(r_p0) < $signed(r_p1);
            r_eq  <= r_p0 == r_p1;
            r_gt  <= $signed(r_p0) > $signed(r_p1);
        end
        if (i_cmd.gcd_init) begin
            r_gx    <= r_mn;
            r_gy    <= r_md;
            r_shift <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx    <= r_gx >> 1;
                r_gy    <= r_gy >> 1;
                r_shift <= r_shift + 7'd1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else begin
                r_gx <= (r_gx < r_gy) ? r_gx : r_gy;
                r_gy <= w_diff;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_gx << r_shift;
            r_qn  <= r_mn;
            r_qd  <= r_md;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 7'd1;
            if (!w_tn[64]) begin
                r_rn <= w_tn[63:0];
                r_qn <= {r_qn[62:0], 1'b1};
            end else begin
                r_rn <= {r_rn[62:0], r_qn[63]};
                r_qn <= {r_qn[62:0], 1'b0};
            end
            if (!w_td[64]) begin
                r_rd <= w_td[63:0];
                r_qd <= {r_qd[62:0], 1'b1};
            end else begin
                r_rd <= {r_rd[62:0], r_qd[63]};
                r_qd <= {r_qd[62:0], 1'b0};
            end
        end
    end

    assign o_stat.err      = r_err;
    assign o_stat.is_cmp   = (r_op == OP_CMP);
    assign o_stat.zero_num = (r_mn == '0);
    assign o_stat.gcd_done = (r_gy == '0);
    assign o_stat.div_done = (r_cnt == 7'd64);

    // Build the result beat.
    always_comb begin
        o_out = '0;
        if (r_err) begin
            o_out.status = 1'b1;
        end else if (r_op == OP_CMP) begin
            o_out.cmp_less    = r_lt;
            o_out.cmp_equal   = r_eq;
            o_out.cmp_greater = r_gt;
        end else if (r_mn == '0) begin
            o_out.res_den = 63'd1;
        end else begin
            o_out.res_num = r_neg ? 64'd0 - r_qn : r_qn;
            o_out.res_den = r_qd[62:0];
        end
    end
endmodule
